@@ hdl/vector_cosine_unit_defines.svh @@
// Assertion macros for the vector cosine unit.
// No dependencies; included by files that check their own logic.
`ifndef VECTOR_COSINE_UNIT_DEFINES_SVH
`define VECTOR_COSINE_UNIT_DEFINES_SVH

// check that a condition implies an expression in the same cycle
`define VCU_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("vector_cosine_unit: same-cycle check failed");

// check that a condition implies an expression in the next cycle
`define VCU_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("vector_cosine_unit: next-cycle check failed");

`endif

@@ hdl/vcu_pkg.sv @@
// Shared constants and types for the vector cosine unit.
// No dependencies.
package vcu_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRAC_BITS       = 14;
    localparam int COS_WIDTH       = 16;
    localparam int QUOT_WIDTH      = 2 * FRAC_BITS + 1;
    localparam int ROOT_WIDTH      = FRAC_BITS + 1;
    localparam int TRIAL_WIDTH     = 2 * ROOT_WIDTH + 1;

    typedef struct packed {
        logic dneg;
        logic zero;
    } tag_t;

endpackage

@@ hdl/vcu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vcu_pkg for the quotient width and the tag type.
module vcu_div #(
    parameter int DW = 4 * vcu_pkg::COMPONENT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [DW-1:0]                 dividend,
    input  logic [DW-1:0]                 divisor,
    input  vcu_pkg::tag_t                 in_tag,
    output logic                          out_valid,
    output logic [vcu_pkg::QUOT_WIDTH-1:0] quotient,
    output vcu_pkg::tag_t                 out_tag
);

    localparam int QW = vcu_pkg::QUOT_WIDTH;

    logic [QW-1:0]   valid_reg;
    logic [DW:0]     rem_reg [QW];
    logic [QW-1:0]   quo_reg [QW];
    logic [DW-1:0]   dvs_reg [QW];
    vcu_pkg::tag_t   tag_reg [QW];

    logic [DW:0]     rem_in   [QW];
    logic [DW:0]     rem_next [QW];
    logic [QW-1:0]   quo_next [QW];
    logic [QW-1:0]   take;

    always_comb
    begin
        rem_in[0]   = {1'b0, dividend};
        take[0]     = rem_in[0] >= {1'b0, divisor};
        rem_next[0] = take[0] ? rem_in[0] - {1'b0, divisor} : rem_in[0];
        quo_next[0] = {{(QW-1){1'b0}}, take[0]};
        for (int k = 1; k < QW; k++)
        begin
            rem_in[k]   = {rem_reg[k-1][DW-1:0], 1'b0};
            take[k]     = rem_in[k] >= {1'b0, dvs_reg[k-1]};
            rem_next[k] = take[k] ? rem_in[k] - {1'b0, dvs_reg[k-1]} : rem_in[k];
            quo_next[k] = {quo_reg[k-1][QW-2:0], take[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_next[0];
            quo_reg[0] <= quo_next[0];
            dvs_reg[0] <= divisor;
            tag_reg[0] <= in_tag;
            for (int k = 1; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                dvs_reg[k] <= dvs_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quotient  = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

@@ hdl/vcu_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on vcu_pkg for the operand widths and the tag type.
module vcu_isqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [vcu_pkg::QUOT_WIDTH-1:0] radicand,
    input  vcu_pkg::tag_t                  in_tag,
    output logic                           out_valid,
    output logic [vcu_pkg::ROOT_WIDTH-1:0] root,
    output vcu_pkg::tag_t                  out_tag
);

    localparam int RW = vcu_pkg::ROOT_WIDTH;
    localparam int TW = vcu_pkg::TRIAL_WIDTH;

    logic [RW-1:0]  valid_reg;
    logic [TW-1:0]  rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    vcu_pkg::tag_t  tag_reg  [RW];

    logic [TW-1:0]  rem_in    [RW];
    logic [RW-1:0]  root_in   [RW];
    logic [TW-1:0]  trial     [RW];
    logic [TW-1:0]  rem_next  [RW];
    logic [RW-1:0]  root_next [RW];

    always_comb
    begin
        rem_in[0]  = TW'(radicand);
        root_in[0] = '0;
        for (int k = 1; k < RW; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            root_in[k] = root_reg[k-1];
        end
        for (int k = 0; k < RW; k++)
        begin
            trial[k] = (TW'(root_in[k]) << (RW - k)) | (TW'(1) << (2 * (RW - 1 - k)));
            if (rem_in[k] >= trial[k])
            begin
                rem_next[k]  = rem_in[k] - trial[k];
                root_next[k] = root_in[k] | (RW'(1) << (RW - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_in[k];
                root_next[k] = root_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[RW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            for (int k = 1; k < RW; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
            for (int k = 0; k < RW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_tag   = tag_reg[RW-1];

endmodule

@@ hdl/vector_cosine_unit.sv @@
// Cosine of the angle between two 3D vectors, fully pipelined.
// Depends on vcu_pkg, vcu_div, vcu_isqrt and vector_cosine_unit_defines.svh.
//
// The unit takes one pair of vectors per clock while s_tready is high and
// returns one word per pair, in order, through 5 front stages for magnitudes,
// products, sums and the wide product and square, 29 divider stages, 15
// square-root stages and the output register. The cosine is the square root
// of dot^2 * 2^28 / (|a|^2 * |b|^2), signed like the dot product, in Q1.14.
// A pair with a zero vector gives cosine 0 with the zero_length flag set.
// When the output word is not taken, the whole pipeline holds and s_tready drops.
`include "vector_cosine_unit_defines.svh"

module vector_cosine_unit #(
    parameter int COMPONENT_WIDTH = vcu_pkg::COMPONENT_WIDTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, zero fill to whole bytes
    input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // cosine
    output logic [vcu_pkg::COS_WIDTH-1:0]               m_tdata,
    // zero_length
    output logic                                        m_tuser
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int PRW = 2 * W - 1;
    localparam int SW  = 2 * W;
    localparam int DW  = 4 * W;
    localparam int QW  = vcu_pkg::QUOT_WIDTH;
    localparam int RW  = vcu_pkg::ROOT_WIDTH;
    localparam int CW  = vcu_pkg::COS_WIDTH;
    localparam logic signed [CW-1:0] COS_ONE = CW'(1 << vcu_pkg::FRAC_BITS);

    logic adv;
    logic [4:0] valid_reg;

    logic [W-1:0]   am_reg [3];
    logic [W-1:0]   bm_reg [3];
    logic [2:0]     an_reg;
    logic [2:0]     bn_reg;
    logic [W-1:0]   am_next [3];
    logic [W-1:0]   bm_next [3];
    logic [2:0]     an_next;
    logic [2:0]     bn_next;

    logic [PRW-1:0] sqa_reg [3];
    logic [PRW-1:0] sqb_reg [3];
    logic [PRW-1:0] ab_reg  [3];
    logic [2:0]     abneg_reg;
    logic [SW-1:0]  sqa_full [3];
    logic [SW-1:0]  sqb_full [3];
    logic [SW-1:0]  ab_full  [3];

    logic [SW-1:0]  na_reg;
    logic [SW-1:0]  nb_reg;
    logic [SW-1:0]  pos_reg;
    logic [SW-1:0]  negs_reg;
    logic [SW-1:0]  pos_next;
    logic [SW-1:0]  negs_next;

    logic [SW-1:0]  na4_reg;
    logic [SW-1:0]  nb4_reg;
    logic [SW-1:0]  dmag_reg;
    vcu_pkg::tag_t  tag4_reg;

    logic [DW-1:0]  prod_reg;
    logic [DW-1:0]  dsq_reg;
    vcu_pkg::tag_t  tag5_reg;

    logic                div_valid;
    logic [QW-1:0]       div_quot;
    vcu_pkg::tag_t       div_tag;
    logic                sq_valid;
    logic [RW-1:0]       sq_root;
    vcu_pkg::tag_t       sq_tag;

    logic           out_valid_reg;
    logic [CW-1:0]  cos_reg;
    logic           zero_reg;
    logic [CW-1:0]  cos_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            an_next[i] = s_tdata[i*W + W - 1];
            bn_next[i] = s_tdata[(i+3)*W + W - 1];
            am_next[i] = an_next[i] ? -s_tdata[i*W +: W] : s_tdata[i*W +: W];
            bm_next[i] = bn_next[i] ? -s_tdata[(i+3)*W +: W] : s_tdata[(i+3)*W +: W];
            sqa_full[i] = am_reg[i] * am_reg[i];
            sqb_full[i] = bm_reg[i] * bm_reg[i];
            ab_full[i]  = am_reg[i] * bm_reg[i];
        end
        pos_next  = '0;
        negs_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (abneg_reg[i])
            begin
                negs_next = negs_next + SW'(ab_reg[i]);
            end
            else
            begin
                pos_next = pos_next + SW'(ab_reg[i]);
            end
        end
        if (sq_tag.zero)
        begin
            cos_next = '0;
        end
        else if (sq_tag.dneg)
        begin
            cos_next = -CW'(sq_root);
        end
        else
        begin
            cos_next = CW'(sq_root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[3:0], s_tvalid};
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                am_reg[i]  <= am_next[i];
                bm_reg[i]  <= bm_next[i];
                sqa_reg[i] <= sqa_full[i][PRW-1:0];
                sqb_reg[i] <= sqb_full[i][PRW-1:0];
                ab_reg[i]  <= ab_full[i][PRW-1:0];
            end
            an_reg    <= an_next;
            bn_reg    <= bn_next;
            abneg_reg <= an_reg ^ bn_reg;

            na_reg   <= SW'(sqa_reg[0]) + SW'(sqa_reg[1]) + SW'(sqa_reg[2]);
            nb_reg   <= SW'(sqb_reg[0]) + SW'(sqb_reg[1]) + SW'(sqb_reg[2]);
            pos_reg  <= pos_next;
            negs_reg <= negs_next;

            na4_reg       <= na_reg;
            nb4_reg       <= nb_reg;
            tag4_reg.dneg <= negs_reg > pos_reg;
            tag4_reg.zero <= (na_reg == '0) || (nb_reg == '0);
            dmag_reg      <= (negs_reg > pos_reg) ? negs_reg - pos_reg : pos_reg - negs_reg;

            prod_reg <= na4_reg * nb4_reg;
            dsq_reg  <= dmag_reg * dmag_reg;
            tag5_reg <= tag4_reg;

            cos_reg  <= cos_next;
            zero_reg <= sq_tag.zero;
        end
    end

    vcu_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (valid_reg[4]),
        .dividend  (dsq_reg),
        .divisor   (prod_reg),
        .in_tag    (tag5_reg),
        .out_valid (div_valid),
        .quotient  (div_quot),
        .out_tag   (div_tag)
    );

    vcu_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div_valid),
        .radicand  (div_quot),
        .in_tag    (div_tag),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cos_reg;
    assign m_tuser  = zero_reg;

    `VCU_ASSERT_IMP(a_cos_range, m_tvalid, ($signed(m_tdata) <= COS_ONE) && ($signed(m_tdata) >= -COS_ONE))
    `VCU_ASSERT_IMP(a_zero_cos, m_tvalid && m_tuser, m_tdata == '0)
    `VCU_ASSERT_IMP(a_quot_bound, div_valid && !div_tag.zero, div_quot <= (QW'(1) << (QW - 1)))
    `VCU_ASSERT_NXT(a_enter, s_tvalid && s_tready, valid_reg[0])

endmodule
